@@ hw/rtl/h264_rtp_fu_a_packetizer_top_macros.svh @@
// ============================================================================
// Assertion macros for the H.264 RTP FU-A packetizer
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ============================================================================
`ifndef H264_RTP_FU_A_PACKETIZER_TOP_MACROS_SVH
`define H264_RTP_FU_A_PACKETIZER_TOP_MACROS_SVH

`ifndef SYNTH
`define H264FU_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define H264FU_ASSERT_CLK(label, clk, rst, prop, msg)
`endif

`ifndef SYNTH
`define H264FU_ASSERT(label, prop, msg) \
   `H264FU_ASSERT_CLK(label, clock, reset, prop, msg)
`else
`define H264FU_ASSERT(label, prop, msg)
`endif

`endif

@@ hw/rtl/h264fu_pkg.sv @@
// ============================================================================
// H.264 RTP FU-A packetizer package
// Field widths, header constants, register indexes and shared types.
// ============================================================================
package h264fu_pkg;

   localparam int DATA_W    = 8;
   localparam int LEN_W     = 16;
   localparam int SEQ_W     = 16;
   localparam int TS_W      = 32;
   localparam int MAXPAY_W  = 16;
   localparam int TSSTEP_W  = 17;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 1;

   localparam logic [MAXPAY_W-1:0] MAX_PAYLOAD_RESET    = 16'd1400;
   localparam logic [TSSTEP_W-1:0] TIMESTAMP_STEP_RESET = 17'd3000;

   // NAL and FU-A header fields.
   localparam logic [7:0] NRI_MASK  = 8'h60;
   localparam logic [7:0] TYPE_MASK = 8'h1F;
   localparam logic [7:0] S_BIT     = 8'h80;
   localparam logic [7:0] E_BIT     = 8'h40;
   localparam logic [7:0] FU_A_TYPE = 8'd28;
   localparam logic [4:0] NAL_SPS   = 5'd7;
   localparam logic [4:0] NAL_PPS   = 5'd8;

   // Result queue sizing; one request pushes at most three results.
   localparam int MAX_PUSH   = 3;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_PAYLOAD    = 1'b0,
      CSR_TIMESTAMP_STEP = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] payload_byte;
      logic              packet_first;
      logic              packet_last;
      logic [SEQ_W-1:0]  sequence_number;
      logic [TS_W-1:0]   rtp_timestamp;
      logic              run_last;
   } result_type;

   typedef struct packed {
      logic [1:0]                  count;
      result_type [MAX_PUSH-1:0]   results;
   } push_type;

endpackage

@@ hw/rtl/h264fu_req_if.sv @@
// ============================================================================
// Request channel interface
// Valid/ready channel carrying one NAL unit byte and the unit length.
// ============================================================================
interface h264fu_req_if;
   import h264fu_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic [LEN_W-1:0]  unit_length;

   modport source (output valid, output data_byte, output unit_length, input ready);
   modport sink   (input valid, input data_byte, input unit_length, output ready);
endinterface

@@ hw/rtl/h264fu_rsp_if.sv @@
// ============================================================================
// Result channel interface
// Valid/ready channel carrying one RTP payload byte and its packet fields.
// ============================================================================
interface h264fu_rsp_if;
   import h264fu_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] payload_byte;
   logic              packet_first;
   logic              packet_last;
   logic [SEQ_W-1:0]  sequence_number;
   logic [TS_W-1:0]   rtp_timestamp;
   logic              run_last;

   modport source (output valid, output payload_byte, output packet_first,
                   output packet_last, output sequence_number, output rtp_timestamp,
                   output run_last, input ready);
   modport sink   (input valid, input payload_byte, input packet_first,
                   input packet_last, input sequence_number, input rtp_timestamp,
                   input run_last, output ready);
endinterface

@@ hw/rtl/h264fu_fifo.sv @@
// ============================================================================
// Result queue
// Takes up to three results per cycle and hands out one per cycle while rsp_ch.ready is high.
// ============================================================================
module h264fu_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  h264fu_pkg::push_type push,
   output logic                 space_ok,
   h264fu_rsp_if.source         rsp_ch
);
   import h264fu_pkg::*;

   result_type              mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   head_ff, head_in;
   logic [FIFO_PTR_W-1:0]   tail_ff, tail_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    pop;
   result_type              head_entry;

   assign pop        = rsp_ch.valid && rsp_ch.ready;
   assign space_ok   = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - MAX_PUSH);
   assign head_entry = mem[head_ff];

   assign rsp_ch.valid           = count_ff != '0;
   assign rsp_ch.payload_byte    = head_entry.payload_byte;
   assign rsp_ch.packet_first    = head_entry.packet_first;
   assign rsp_ch.packet_last     = head_entry.packet_last;
   assign rsp_ch.sequence_number = head_entry.sequence_number;
   assign rsp_ch.rtp_timestamp   = head_entry.rtp_timestamp;
   assign rsp_ch.run_last        = head_entry.run_last;

   always_comb begin
      head_in  = head_ff + FIFO_PTR_W'(pop);
      tail_in  = tail_ff + FIFO_PTR_W'(push.count);
      count_in = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (i < int'(push.count)) begin
            mem[tail_ff + FIFO_PTR_W'(i)] <= push.results[i];
         end
      end
   end
endmodule

@@ hw/rtl/h264fu_core.sv @@
// ============================================================================
// Packetizer core
// Input register, unit and fragment state, and result generation per byte.
// ============================================================================
module h264fu_core (
   input  logic                              clock,
   input  logic                              reset,
   h264fu_req_if.sink                        req_ch,
   input  logic                              csr_write_enable,
   input  logic [h264fu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [h264fu_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                              space_ok,
   output h264fu_pkg::push_type              push
);
   import h264fu_pkg::*;

   logic [MAXPAY_W-1:0] max_payload_ff;
   logic [TSSTEP_W-1:0] timestamp_step_ff;

   logic                in_valid_ff;
   logic [DATA_W-1:0]   in_data_ff;
   logic [LEN_W-1:0]    in_len_ff;

   logic [DATA_W-1:0]   unit_header_ff, unit_header_in;
   logic [LEN_W-1:0]    bytes_seen_ff, bytes_seen_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic [LEN_W-1:0]    frag_index_ff, frag_index_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [TS_W-1:0]     time_ff, time_in;
   logic                single_ff, single_in;

   logic                advance;
   logic                accept;
   logic [LEN_W-1:0]    len_eff;
   logic [MAXPAY_W-1:0] mp;
   logic                first;
   logic [DATA_W-1:0]   hdr;
   logic                unit_end;
   logic [LEN_W-1:0]    data_total;
   logic [LEN_W-1:0]    cap;
   logic                pkt_end;
   logic [LEN_W-1:0]    rem;
   logic                frag_data;
   logic [DATA_W-1:0]   indicator;
   logic [DATA_W-1:0]   fu_header;
   logic                ts_skip;
   result_type          base;

   assign advance      = in_valid_ff && space_ok;
   assign req_ch.ready = !in_valid_ff || space_ok;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff    <= MAX_PAYLOAD_RESET;
         timestamp_step_ff <= TIMESTAMP_STEP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_PAYLOAD:    max_payload_ff    <= csr_write_data[MAXPAY_W-1:0];
            CSR_TIMESTAMP_STEP: timestamp_step_ff <= csr_write_data[TSSTEP_W-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_ch.data_byte;
         in_len_ff  <= req_ch.unit_length;
      end
   end

   always_comb begin
      len_eff    = (in_len_ff == '0) ? LEN_W'(1) : in_len_ff;
      mp         = (max_payload_ff == '0) ? MAXPAY_W'(1) : max_payload_ff;
      first      = bytes_seen_ff == '0;
      hdr        = first ? in_data_ff : unit_header_ff;
      single_in  = first ? (len_eff <= mp) : single_ff;
      unit_end   = ({1'b0, bytes_seen_ff} + 17'd1) >= {1'b0, len_eff};
      data_total = len_eff - LEN_W'(1);

      // A unit that would exactly fill the first fragment holds its last
      // byte back, so the first fragment never carries both S and E unless the unit has one data byte.
      if (frag_index_ff == '0 && data_total <= mp && data_total >= LEN_W'(2)) begin
         cap = data_total - LEN_W'(1);
      end else begin
         cap = mp;
      end
      pkt_end   = unit_end || (({1'b0, fill_ff} + 17'd1) >= {1'b0, cap});
      rem       = (bytes_seen_ff < len_eff) ? (len_eff - bytes_seen_ff) : LEN_W'(1);
      frag_data = !single_in && !first;

      indicator = (hdr & NRI_MASK) | FU_A_TYPE;
      fu_header = (hdr & TYPE_MASK)
                | ((frag_index_ff == '0) ? S_BIT : 8'h00)
                | ((rem <= cap) ? E_BIT : 8'h00);
      ts_skip   = single_in && (hdr[4:0] == NAL_SPS || hdr[4:0] == NAL_PPS);

      base.payload_byte    = in_data_ff;
      base.packet_first    = 1'b0;
      base.packet_last     = 1'b0;
      base.sequence_number = seq_ff;
      base.rtp_timestamp   = time_ff;
      base.run_last        = 1'b0;

      push.count   = 2'd0;
      push.results = {MAX_PUSH{base}};
      if (single_in) begin
         push.count                   = 2'd1;
         push.results[0].packet_first = first;
         push.results[0].packet_last  = unit_end;
         push.results[0].run_last     = 1'b1;
      end else if (frag_data) begin
         if (fill_ff == '0) begin
            push.count                   = 2'd3;
            push.results[0].payload_byte = indicator;
            push.results[0].packet_first = 1'b1;
            push.results[1].payload_byte = fu_header;
            push.results[2].packet_last  = pkt_end;
            push.results[2].run_last     = 1'b1;
         end else begin
            push.count                  = 2'd1;
            push.results[0].packet_last = pkt_end;
            push.results[0].run_last    = 1'b1;
         end
      end
      if (!advance) begin
         push.count = 2'd0;
      end

      unit_header_in = hdr;
      seq_in         = seq_ff;
      if ((single_in && unit_end) || (frag_data && pkt_end)) begin
         seq_in = seq_ff + SEQ_W'(1);
      end
      fill_in       = fill_ff;
      frag_index_in = frag_index_ff;
      if (frag_data) begin
         if (pkt_end) begin
            fill_in       = '0;
            frag_index_in = frag_index_ff + LEN_W'(1);
         end else begin
            fill_in = fill_ff + LEN_W'(1);
         end
      end
      time_in = time_ff;
      if (unit_end) begin
         if (!ts_skip) begin
            time_in = time_ff + TS_W'(timestamp_step_ff);
         end
         bytes_seen_in = '0;
         fill_in       = '0;
         frag_index_in = '0;
      end else begin
         bytes_seen_in = bytes_seen_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_header_ff <= '0;
         bytes_seen_ff  <= '0;
         fill_ff        <= '0;
         frag_index_ff  <= '0;
         seq_ff         <= '0;
         time_ff        <= '0;
         single_ff      <= 1'b0;
      end else if (advance) begin
         unit_header_ff <= unit_header_in;
         bytes_seen_ff  <= bytes_seen_in;
         fill_ff        <= fill_in;
         frag_index_ff  <= frag_index_in;
         seq_ff         <= seq_in;
         time_ff        <= time_in;
         single_ff      <= single_in;
      end
   end
endmodule

@@ hw/rtl/h264_rtp_fu_a_packetizer_top.sv @@
// ============================================================================
// H.264 RTP FU-A packetizer
// Turns NAL unit bytes into RTP payload bytes, fragmenting long units.
// ============================================================================
//
//   Channel  Direction  Handshake          Carries
//   req_ch   in         valid/ready        data_byte, unit_length
//   rsp_ch   out        valid/ready        payload byte, packet flags, seq, timestamp
//   csr_*    in         write enable only  max_payload, timestamp_step
//
// A request is registered, then processed once the queue has room; its results
// enter an eight-entry queue and the first can leave in the cycle after its write.
// One request per cycle is taken while the queue holds at most five results.
// A fragment start adds two header bytes, so even a consumer that takes one
// result every cycle sees the queue grow by two per fragment, and the input
// then stalls until the queue drains. Synchronous reset empties the queue
// and clears all unit state; the registers return to 1400 and 3000.
//
`include "h264_rtp_fu_a_packetizer_top_macros.svh"

module h264_rtp_fu_a_packetizer_top (
   input  logic                              clock,
   input  logic                              reset,
   h264fu_req_if.sink                        req_ch,
   h264fu_rsp_if.source                      rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [h264fu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [h264fu_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import h264fu_pkg::*;

   push_type push;
   logic     space_ok;

   h264fu_core u_core (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .space_ok         (space_ok),
      .push             (push)
   );

   h264fu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_ch   (rsp_ch)
   );

   `H264FU_ASSERT(a_push_needs_room, push.count != 2'd0 |-> space_ok, "push without queue room")
   `H264FU_ASSERT(a_fragment_start_shape,
      push.count == 2'd3 |-> (push.results[0].packet_first && !push.results[0].run_last
         && !push.results[1].run_last && push.results[2].run_last),
      "bad fragment start")
   `H264FU_ASSERT(a_single_push_last, push.count == 2'd1 |-> push.results[0].run_last,
      "single result without run_last")
   `H264FU_ASSERT(a_empty_after_reset, $past(reset) |-> !rsp_ch.valid,
      "result valid right after reset")
endmodule
